FILE: hw/rtl/csq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore wait queue package
// Shared widths, command and status codes, and the word types passed between
// the front end, the execution engine and the result queue.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 8;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TOTAL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 11;
    localparam int INIT_W  = 10;
    localparam int TID_W   = THREAD_ID_BITS;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1023);
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = COUNT_W'(-QUEUE_DEPTH);

    localparam logic [CMD_W-1:0] CMD_WAIT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SIGNAL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TRY    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd4;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_WAIT   = 3'd1;
    localparam logic [2:0] OP_SIGNAL = 3'd2;
    localparam logic [2:0] OP_TRY    = 3'd3;
    localparam logic [2:0] OP_CLOSE  = 3'd4;
    localparam logic [2:0] OP_OPEN   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BLOCKED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_TRY_FAIL = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SAT      = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [TID_W-1:0] tid;
    } front_word_t;

    typedef struct packed {
        logic                      valid;
        front_word_t               word;
    } front_out_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [COUNT_W-1:0] count_after;
        logic                      wake_valid;
        logic [TID_W-1:0]          wake_thread;
        logic                      last;
    } result_word_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/csq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore front end
// Accepts command words, decodes each command into an operation and holds
// them in a two-entry queue until the engine takes them.
// ----------------------------------------------------------------------------
module csq_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [csq_pkg::CMD_W-1:0]   cmd,
    input  wire logic [csq_pkg::TID_W-1:0]   thread_id,
    output csq_pkg::front_out_t              front_out,
    input  wire logic                        take
);

    csq_pkg::front_word_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic [2:0] op_dec;
    logic       wr_en;
    logic       rd_en;

    always_comb
    begin
        case (cmd)
            csq_pkg::CMD_WAIT:   op_dec = csq_pkg::OP_WAIT;
            csq_pkg::CMD_SIGNAL: op_dec = csq_pkg::OP_SIGNAL;
            csq_pkg::CMD_TRY:    op_dec = csq_pkg::OP_TRY;
            csq_pkg::CMD_CLOSE:  op_dec = csq_pkg::OP_CLOSE;
            csq_pkg::CMD_OPEN:   op_dec = csq_pkg::OP_OPEN;
            default:             op_dec = csq_pkg::OP_NOP;
        endcase
    end

    assign full  = (fill_reg == 2'd2);
    assign wr_en = push && !full;
    assign rd_en = take && (fill_reg != 2'd0);

    assign front_out.valid = (fill_reg != 2'd0);
    assign front_out.word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg].op  <= op_dec;
            entry_reg[wr_ptr_reg].tid <= thread_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csq_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore execution engine
// Holds the count, the initial count register and the FIFO of blocked thread
// identifiers. While the result queue has room it carries out one operation
// per cycle; a close held at the front queue head frees one waiter per cycle.
// ----------------------------------------------------------------------------
module csq_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [csq_pkg::INIT_W-1:0]  initial_count,
    input  wire csq_pkg::front_out_t         front_out,
    output logic                             take,
    input  wire logic                        res_full,
    output logic                             res_push,
    output csq_pkg::result_word_t            res_word
);

    logic [csq_pkg::INIT_W-1:0]         init_reg;
    logic signed [csq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [csq_pkg::TID_W-1:0]          waiter_reg [csq_pkg::QUEUE_DEPTH];
    logic [csq_pkg::PTR_W-1:0]          head_reg, head_next;
    logic [csq_pkg::PTR_W-1:0]          tail_reg, tail_next;
    logic [csq_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic                               enq;
    logic signed [csq_pkg::COUNT_W-1:0] count_dec;
    logic signed [csq_pkg::COUNT_W-1:0] count_inc;
    logic                               fire;

    assign count_dec = count_reg - csq_pkg::COUNT_W'(1);
    assign count_inc = count_reg + csq_pkg::COUNT_W'(1);
    assign fire      = front_out.valid && !res_full;
    assign res_push  = fire;

    always_comb
    begin
        count_next           = count_reg;
        head_next            = head_reg;
        tail_next            = tail_reg;
        total_next           = total_reg;
        enq                  = 1'b0;
        take                 = fire;
        res_word.status      = csq_pkg::STAT_DONE;
        res_word.wake_valid  = 1'b0;
        res_word.wake_thread = '0;
        res_word.last        = 1'b1;
        if (fire)
        begin
            case (front_out.word.op)
                csq_pkg::OP_WAIT:
                begin
                    if (count_reg > csq_pkg::COUNT_W'(0))
                    begin
                        count_next = count_dec;
                    end
                    else if (total_reg >= csq_pkg::TOTAL_W'(csq_pkg::QUEUE_DEPTH)
                             || count_reg <= csq_pkg::COUNT_MIN)
                    begin
                        res_word.status = csq_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        count_next      = count_dec;
                        enq             = 1'b1;
                        tail_next       = csq_pkg::next_slot(tail_reg);
                        total_next      = total_reg + csq_pkg::TOTAL_W'(1);
                        res_word.status = csq_pkg::STAT_BLOCKED;
                    end
                end
                csq_pkg::OP_SIGNAL:
                begin
                    if (count_reg >= csq_pkg::COUNT_MAX)
                    begin
                        res_word.status = csq_pkg::STAT_SAT;
                    end
                    else
                    begin
                        count_next = count_inc;
                        if (count_inc <= csq_pkg::COUNT_W'(0) && total_reg != '0)
                        begin
                            res_word.wake_valid  = 1'b1;
                            res_word.wake_thread = waiter_reg[head_reg];
                            head_next            = csq_pkg::next_slot(head_reg);
                            total_next           = total_reg - csq_pkg::TOTAL_W'(1);
                        end
                    end
                end
                csq_pkg::OP_TRY:
                begin
                    if (count_reg > csq_pkg::COUNT_W'(0))
                    begin
                        count_next = count_dec;
                    end
                    else
                    begin
                        res_word.status = csq_pkg::STAT_TRY_FAIL;
                    end
                end
                csq_pkg::OP_CLOSE:
                begin
                    if (total_reg == '0)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        res_word.wake_valid  = 1'b1;
                        res_word.wake_thread = waiter_reg[head_reg];
                        res_word.last        = (total_reg == csq_pkg::TOTAL_W'(1));
                        total_next           = total_reg - csq_pkg::TOTAL_W'(1);
                        head_next            = csq_pkg::next_slot(head_reg);
                        take                 = res_word.last;
                        if (res_word.last)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                end
                csq_pkg::OP_OPEN:
                begin
                    count_next = csq_pkg::COUNT_W'(init_reg);
                    head_next  = '0;
                    tail_next  = '0;
                    total_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        res_word.count_after = count_next;
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            waiter_reg[tail_reg] <= front_out.word.tid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= '0;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                init_reg <= initial_count;
            end
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            total_reg <= total_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csq_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore result queue
// Four-entry queue of result words between the engine and the consumer.
// ----------------------------------------------------------------------------
module csq_result_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire csq_pkg::result_word_t  wr_word,
    output logic                        res_full,
    input  wire logic                   pop,
    output logic                        empty,
    output csq_pkg::result_word_t       rd_word
);

    csq_pkg::result_word_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg, fill_next;
    logic       do_wr;
    logic       do_rd;

    assign res_full = (fill_reg == 3'd4);
    assign empty    = (fill_reg == 3'd0);
    assign do_wr    = wr_en && !res_full;
    assign do_rd    = pop && !empty;
    assign rd_word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 2'(do_wr);
        rd_ptr_next = rd_ptr_reg + 2'(do_rd);
        fill_next   = fill_reg + 3'(do_wr) - 3'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/counting_semaphore_wait_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Counting semaphore wait queue, top level
// Command words (cmd, thread_id) are written with push while full is low.
// Result words (status, count_after, wake_valid, wake_thread, last) are read
// with pop while empty is low; last marks the final word of a command.
// initial_count is written with cfg_wr_en while the block is idle.
// A command passes through the front queue and the result queue before its
// first result word reaches the result ports.
// Wait, signal, try_wait, open and unknown commands give one word. Close
// gives one word per released waiter, or one word when no thread waits.
// Except for a close that releases waiters, the engine takes one command per
// cycle while the result queue has room, by a single read-modify-write of
// the count and queue pointers.
// Reset clears the count, the initial count and the wait queue, and empties
// both internal queues. When the consumer stalls, the four-word result queue
// fills, the engine holds, and the two-word front queue then raises full.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [csq_pkg::CMD_W-1:0]            cmd,
    input  wire logic [csq_pkg::TID_W-1:0]            thread_id,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic [csq_pkg::STAT_W-1:0]                status,
    output logic signed [csq_pkg::COUNT_W-1:0]        count_after,
    output logic                                      wake_valid,
    output logic [csq_pkg::TID_W-1:0]                 wake_thread,
    output logic                                      last,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [csq_pkg::INIT_W-1:0]           initial_count
);

    csq_pkg::front_out_t   front_out;
    csq_pkg::result_word_t res_in;
    csq_pkg::result_word_t res_out;
    logic                  take;
    logic                  res_full;
    logic                  res_push;

    csq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .thread_id (thread_id),
        .front_out (front_out),
        .take      (take)
    );

    csq_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .initial_count (initial_count),
        .front_out     (front_out),
        .take          (take),
        .res_full      (res_full),
        .res_push      (res_push),
        .res_word      (res_in)
    );

    csq_result_fifo u_result_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .wr_word  (res_in),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .rd_word  (res_out)
    );

    assign status      = res_out.status;
    assign count_after = res_out.count_after;
    assign wake_valid  = res_out.wake_valid;
    assign wake_thread = res_out.wake_thread;
    assign last        = res_out.last;

endmodule
`default_nettype wire
